### rtl/rps_pkg.sv
package rps_pkg;

    localparam int AccW = 40;
    localparam int MotW = 32;
    localparam int SmpW = 16;
    localparam int PotW = 17;
    localparam int SumW = 48;
    localparam int NumW = AccW + 16;

    localparam logic [1:0] KIND_MOTOR  = 2'd0;
    localparam logic [1:0] KIND_SET    = 2'd1;
    localparam logic [1:0] KIND_DECIDE = 2'd2;

    localparam logic CFG_HIGHEST = 1'b0;
    localparam logic CFG_WEIGHT  = 1'b1;

    localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
    localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};
    localparam logic [PotW-1:0] OneQ16 = 17'h10000;

    function automatic logic signed [AccW-1:0] sat_add(
        input logic signed [AccW-1:0] a,
        input logic signed [AccW-1:0] b
    );
        logic signed [AccW:0] s;
        s = {a[AccW-1], a} + {b[AccW-1], b};
        if (s[AccW] != s[AccW-1]) begin
            sat_add = s[AccW] ? AccMin : AccMax;
        end else begin
            sat_add = s[AccW-1:0];
        end
    endfunction

    typedef struct packed {
        logic start;
        logic [NumW-1:0] num;
        logic [SumW-1:0] den;
    } t_div_req;

endpackage

### rtl/rps_divider.sv
module rps_divider
    import rps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [PotW-1:0]  o_quot
);
    // restoring division, one quotient bit per cycle; quotient fits 17 bits
    logic [NumW-1:0] r_num;
    logic [SumW:0]   r_rem;
    logic [SumW-1:0] r_den;
    logic [PotW-1:0] r_quot;
    logic [6:0]      r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [SumW:0]   w_sh;
    logic [SumW:0]   w_sub;

    assign w_sh  = {r_rem[SumW-1:0], r_num[NumW-1]};
    assign w_sub = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_cnt == 7'd1);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(NumW);
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_quot <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[NumW-2:0], 1'b0};
                if (!w_sub[SumW]) begin
                    r_rem  <= w_sub;
                    r_quot <= {r_quot[PotW-2:0], 1'b1};
                end else begin
                    r_rem  <= w_sh;
                    r_quot <= {r_quot[PotW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

### rtl/response_potential_selector.sv
// channel   | dir | tdata fields (low bit first)                         | tuser
// s_axis    | in  | response_index, motive, inhibited, override_potential,| kind
//           |     | random_sample, override_valid, override_response      |
// m_axis    | out | selected_response, none_selected, selected_potential  | -
// cfg       | in  | i_cfg_wr_en, i_cfg_index, i_cfg_data                  | -
// motor items go through memory read, modify and write (S_RMW, S_WB); settings items are written as they are taken
// a decide item makes a pass over the responses in use for the minimum, a pass for the sum,
// then per response a read, a serial divide and a mix, then done, out and a clearing
// pass; with a zero sum the serial divide is skipped
// reset is synchronous; a pass over all NUM_RESPONSES entries after reset clears all
// memories, and after each decide it clears the accumulators; no item is taken then
// the result register frees the input side while a result waits; a decide
// stalls in its done step until the previous result has been taken
module response_potential_selector
    import rps_pkg::*;
#(
    parameter int NUM_RESPONSES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,  // index 4, motive 32, inhibited 1, override 32,
                                        // sample 16, override_valid 1, override_resp 4
    input  logic [1:0]   s_axis_tuser,  // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [23:0]  m_axis_tdata,  // selected_response 4, none_selected 1, potential 17
    input  logic         i_cfg_wr_en,
    input  logic         i_cfg_index,
    input  logic [16:0]  i_cfg_data
);
    localparam int IW = (NUM_RESPONSES > 1) ? $clog2(NUM_RESPONSES) : 1;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_RMW   = 11'b00000000100,
        S_WB    = 11'b00000001000,
        S_P1    = 11'b00000010000,
        S_P2    = 11'b00000100000,
        S_P3RD  = 11'b00001000000,
        S_P3DIV = 11'b00010000000,
        S_P3MIX = 11'b00100000000,
        S_DONE  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    // memories
    logic signed [AccW-1:0] acc_mem [NUM_RESPONSES];
    logic signed [MotW-1:0] ovr_mem [NUM_RESPONSES];
    logic [SmpW-1:0]        smp_mem [NUM_RESPONSES];
    logic [NUM_RESPONSES-1:0] r_inh;

    t_state r_state;
    logic          r_init;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_last;
    logic [3:0]    r_highest;
    logic [16:0]   r_weight;
    logic signed [AccW-1:0] r_acc_rd;
    logic signed [MotW-1:0] r_ovr_rd;
    logic [SmpW-1:0]        r_smp_rd;
    logic signed [AccW-1:0] r_mn;
    logic [SumW-1:0]        r_sum;
    logic signed [MotW-1:0] r_motive;
    logic       r_ovv;
    logic [3:0] r_ovr;
    logic       r_found;
    logic [3:0] r_best;
    logic [PotW-1:0] r_bestpot;
    logic [1:0] r_ph;
    logic       r_oval;
    logic [23:0] r_odata;
    logic [PotW-1:0] r_mixq;
    t_div_req w_req;
    logic     w_done;
    logic [PotW-1:0] w_quot;

    logic [1:0]  w_kind;
    logic [3:0]  w_ridx;
    logic        w_acc;
    logic signed [AccW-1:0] w_p;
    logic [AccW-1:0] w_pn;
    logic [16:0] w_w;
    logic [34:0] w_mix;

    assign w_kind = s_axis_tuser;
    assign w_ridx = s_axis_tdata[3:0];
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign w_w   = (r_weight > OneQ16) ? OneQ16 : r_weight;

    // saturated per-response potential and its offset from the minimum
    assign w_p  = sat_add(r_acc_rd, {{(AccW-MotW){r_ovr_rd[MotW-1]}}, r_ovr_rd});
    assign w_pn = AccW'(w_p - r_mn);
    assign w_mix = 35'(r_mixq) * 35'(OneQ16 - w_w) + 35'(r_smp_rd) * 35'(w_w)
                   + 35'd32768;

    always_comb begin
        w_req.start = (r_state == S_P3DIV) && (r_ph == 2'd0) && (r_sum != '0);
        w_req.num   = {w_pn, 16'd0};
        w_req.den   = r_sum;
    end

    rps_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_done (w_done),
        .o_quot (w_quot)
    );

    // memory ports: one read, one write per memory per cycle
    always_ff @(posedge i_clk) begin
        r_acc_rd <= acc_mem[r_idx];
        r_ovr_rd <= ovr_mem[r_idx];
        r_smp_rd <= smp_mem[r_idx];
        if (r_state == S_CLEAR) begin
            acc_mem[r_idx] <= '0;
        end else if (r_state == S_WB) begin
            acc_mem[r_idx] <= sat_add(r_acc_rd,
                {{(AccW-MotW){r_motive[MotW-1]}}, r_motive});
        end
        // settings memories start at zero after reset
        if (r_state == S_CLEAR && r_init) begin
            ovr_mem[r_idx] <= '0;
            smp_mem[r_idx] <= '0;
        end else if (w_acc && w_kind == KIND_SET && 32'(w_ridx) < NUM_RESPONSES) begin
            ovr_mem[IW'(w_ridx)] <= s_axis_tdata[68:37];
            smp_mem[IW'(w_ridx)] <= s_axis_tdata[84:69];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_init   <= 1'b1;
            r_idx    <= '0;
            r_inh    <= '0;
            r_highest <= 4'd15;
            r_weight <= '0;
            r_oval   <= 1'b0;
            r_ph     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_HIGHEST) r_highest <= i_cfg_data[3:0];
                else r_weight <= i_cfg_data;
            end
            if (r_state == S_DONE && (!r_oval || m_axis_tready)) begin
                r_oval <= 1'b1;
            end else if (r_oval && m_axis_tready) begin
                r_oval <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (32'(r_idx) == NUM_RESPONSES - 1) begin
                        r_idx   <= '0;
                        r_init  <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_IDLE: begin
                    if (w_acc) begin
                        r_motive <= s_axis_tdata[35:4];
                        r_ovv    <= s_axis_tdata[85];
                        r_ovr    <= s_axis_tdata[89:86];
                        if (w_kind == KIND_MOTOR && 32'(w_ridx) < NUM_RESPONSES) begin
                            r_idx   <= IW'(w_ridx);
                            r_state <= S_RMW;
                        end else if (w_kind == KIND_SET
                                     && 32'(w_ridx) < NUM_RESPONSES) begin
                            r_inh[IW'(w_ridx)] <= s_axis_tdata[36];
                        end else if (w_kind == KIND_DECIDE) begin
                            r_last <= (32'(r_highest) > NUM_RESPONSES - 1)
                                      ? IW'(NUM_RESPONSES - 1) : IW'(r_highest);
                            r_idx   <= '0;
                            r_mn    <= '0;
                            r_sum   <= '0;
                            r_found <= 1'b0;
                            r_best  <= '0;
                            r_bestpot <= '0;
                            r_ph    <= '0;
                            r_state <= S_P1;
                        end
                    end
                end
                S_RMW: r_state <= S_WB;
                S_WB: begin
                    r_idx   <= '0;
                    r_state <= S_IDLE;
                end
                // pass 1: minimum (at most zero); read issued at r_idx, data the next cycle
                S_P1: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph <= 2'd0;
                        if (!r_inh[r_idx] && w_p < r_mn) r_mn <= w_p;
                        if (r_idx == r_last) begin
                            r_idx   <= '0;
                            r_state <= S_P2;
                        end else begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                end
                S_P2: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph <= 2'd0;
                        if (!r_inh[r_idx]) r_sum <= r_sum + SumW'(w_pn);
                        if (r_idx == r_last) begin
                            r_idx   <= '0;
                            r_state <= S_P3RD;
                        end else begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                end
                S_P3RD: begin
                    r_ph    <= '0;
                    r_state <= S_P3DIV;
                end
                S_P3DIV: begin
                    if (r_sum == '0) begin
                        r_mixq  <= '0;
                        r_state <= S_P3MIX;
                    end else if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else if (w_done) begin
                        r_mixq  <= w_quot;
                        r_state <= S_P3MIX;
                    end
                end
                S_P3MIX: begin
                    if (!r_inh[r_idx]) begin
                        if (!r_found || 17'(w_mix[34:16]) > r_bestpot) begin
                            r_found   <= 1'b1;
                            r_best    <= 4'(r_idx);
                            r_bestpot <= 17'(w_mix[34:16]);
                        end
                    end
                    r_idx <= r_idx + IW'(1);
                    r_state <= (r_idx == r_last) ? S_DONE : S_P3RD;
                end
                // wait here while the previous result is still held
                S_DONE: begin
                    if (!r_oval || m_axis_tready) begin
                        r_odata <= {2'b0,
                            r_found ? r_bestpot : 17'd0,
                            (r_ovv ? 1'b0 : !r_found),
                            (r_ovv ? r_ovr : (r_found ? r_best : 4'd0))};
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_idx   <= '0;
                    r_state <= S_CLEAR;
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_odata;
endmodule

### rtl/rps_checker.sv
module rps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3:0] == 4'd0
        && m_axis_tdata[21:5] == 17'd0)
        else $error("none selected with nonzero fields");
    a_pot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[21:5] <= 17'h10000)
        else $error("potential above one");
endmodule

bind response_potential_selector rps_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata));
